// File: hw/rtl/assert_macros.svh
// Assertion helpers; each expects clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/fsr_pkg.sv
package fsr_pkg;

  localparam int DISP_WIDTH  = 128;
  localparam int DISP_HEIGHT = 160;
  localparam int COLS        = DISP_WIDTH + 1;
  localparam int ROWS        = DISP_HEIGHT + 1;
  localparam int NUM_PIX     = COLS * ROWS;
  localparam int ADDR_W      = $clog2(NUM_PIX);
  localparam int COL_W       = $clog2(COLS);
  localparam int ROW_W       = $clog2(ROWS);

  // field widths
  localparam int MODE_W   = 3;
  localparam int POS_W    = 16;
  localparam int RADIUS_W = 15;
  localparam int COLOR_W  = 8;

  // coordinate math: x + 2r spans 18 signed bits, |dx| stays below 2^16
  localparam int COORD_W = 18;
  localparam int SQ_W    = 2 * (COORD_W - 2);
  localparam int RR_W    = 2 * RADIUS_W;

  localparam logic [MODE_W-1:0] MODE_FILL    = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_RECT    = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_OUTLINE = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_CIRCLE  = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_READ    = MODE_W'(4);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_CLR_SCAN,
    ST_CLR_DRAIN,
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } fsr_state_t;

  typedef enum logic [1:0] {
    SCAN_SOLID,
    SCAN_BORDER,
    SCAN_DISC
  } scan_kind_t;

  typedef struct packed {
    logic cmd_load;
    logic clear_setup;
    logic setup;
    logic step;
    logic out_load;
  } fsr_ctl_t;

  typedef struct packed {
    logic draw;
    logic scan_end;
    logic pipe_busy;
    logic out_free;
  } fsr_sts_t;

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [COL_W-1:0] col,
                                                 input logic [ROW_W-1:0] row);
    logic [31:0] full;
    full = 32'(col) * 32'(ROWS) + 32'(row);
    return full[ADDR_W-1:0];
  endfunction

endpackage

// File: hw/rtl/fsr_if.sv
interface fsr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [fsr_pkg::MODE_W-1:0]    mode;
  logic signed [fsr_pkg::POS_W-1:0]     x_pos;
  logic signed [fsr_pkg::POS_W-1:0]     y_pos;
  logic signed [fsr_pkg::POS_W-1:0]     width;
  logic signed [fsr_pkg::POS_W-1:0]     height;
  logic        [fsr_pkg::RADIUS_W-1:0]  radius;
  logic        [fsr_pkg::COLOR_W-1:0]   color;

  modport source (output valid, mode, x_pos, y_pos, width, height, radius, color,
                  input ready);
  modport sink (input valid, mode, x_pos, y_pos, width, height, radius, color,
                output ready);
endinterface

interface fsr_out_if;
  logic                               valid;
  logic                               ready;
  logic [fsr_pkg::COLOR_W-1:0]        read_color;
  logic [fsr_pkg::COLOR_W-1:0]        red_level;
  logic [fsr_pkg::COLOR_W-1:0]        green_level;
  logic [fsr_pkg::COLOR_W-1:0]        blue_level;

  modport source (output valid, read_color, red_level, green_level, blue_level,
                  input ready);
  modport sink (input valid, read_color, red_level, green_level, blue_level,
                output ready);
endinterface

// File: hw/rtl/framebuffer_shape_rasterizer.sv
// RGB332 frame store of 129 x 161 pixels with a shape rasterizer.
// in_bus carries one command per beat (mode, x_pos, y_pos, width, height,
// radius, color); out_bus returns exactly one result beat per command.
// Draw commands (fill all, rectangle, outline, circle) answer with zeros;
// a read returns the stored pixel and its expanded red, green, blue levels,
// or zeros when the coordinate lies outside the store.
// Draws walk their clipped bounding box one pixel per cycle through a
// three-stage pixel pipeline; a full fill covers all 20769 pixels. An empty
// clip still passes through the scan and drain states; reads and unused
// modes skip the walk and go from setup straight to the result.
// One command is in flight at a time; in_bus.ready is high only while the
// block is idle, so the next beat is taken in the cycle after the result is
// loaded at the earliest. After reset the block sweeps the whole store to
// zero through a setup state, a sweep of every pixel and a drain, with
// in_bus.ready held low.
// The result sits in an output register: a stalled receiver holds it, and
// the next command may be accepted and worked while it waits.
module framebuffer_shape_rasterizer (
  input  logic             clk,
  input  logic             rst_n,
  fsr_in_if.sink           in_bus,
  fsr_out_if.source        out_bus
);

  fsr_pkg::fsr_ctl_t ctl;
  fsr_pkg::fsr_sts_t sts;
  logic              in_ready;

  fsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  fsr_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .sts         (sts),
    .mode        (in_bus.mode),
    .x_pos       (in_bus.x_pos),
    .y_pos       (in_bus.y_pos),
    .width       (in_bus.width),
    .height      (in_bus.height),
    .radius      (in_bus.radius),
    .color       (in_bus.color),
    .out_ready   (out_bus.ready),
    .out_valid   (out_bus.valid),
    .read_color  (out_bus.read_color),
    .red_level   (out_bus.red_level),
    .green_level (out_bus.green_level),
    .blue_level  (out_bus.blue_level)
  );

  assign in_bus.ready = in_ready;

endmodule

// File: hw/rtl/fsr_ctrl.sv
`include "assert_macros.svh"

module fsr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fsr_pkg::fsr_sts_t sts,
  output fsr_pkg::fsr_ctl_t ctl
);

  fsr_pkg::fsr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsr_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      fsr_pkg::ST_INIT: begin
        ctl.clear_setup = 1'b1;
        state_nxt       = fsr_pkg::ST_CLR_SCAN;
      end
      fsr_pkg::ST_CLR_SCAN: begin
        ctl.step = 1'b1;
        if (sts.scan_end) state_nxt = fsr_pkg::ST_CLR_DRAIN;
      end
      fsr_pkg::ST_CLR_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = fsr_pkg::ST_IDLE;
      end
      fsr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.cmd_load = 1'b1;
          state_nxt    = fsr_pkg::ST_SETUP;
        end
      end
      fsr_pkg::ST_SETUP: begin
        ctl.setup = 1'b1;
        // reads and unused modes skip the walk
        state_nxt = sts.draw ? fsr_pkg::ST_SCAN : fsr_pkg::ST_DONE;
      end
      fsr_pkg::ST_SCAN: begin
        ctl.step = 1'b1;
        if (sts.scan_end) state_nxt = fsr_pkg::ST_DRAIN;
      end
      fsr_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = fsr_pkg::ST_DONE;
      end
      fsr_pkg::ST_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = fsr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fsr_pkg::ST_INIT;
    endcase
  end

  `ASSERT_NEXT(a_accept_to_setup, in_valid && in_ready, state_r == fsr_pkg::ST_SETUP)
  `ASSERT_IMPL(a_done_after_drain, state_r == fsr_pkg::ST_DONE, !sts.pipe_busy)

endmodule

// File: hw/rtl/fsr_datapath.sv
`include "assert_macros.svh"

module fsr_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  fsr_pkg::fsr_ctl_t                     ctl,
  output fsr_pkg::fsr_sts_t                     sts,
  input  logic        [fsr_pkg::MODE_W-1:0]     mode,
  input  logic signed [fsr_pkg::POS_W-1:0]      x_pos,
  input  logic signed [fsr_pkg::POS_W-1:0]      y_pos,
  input  logic signed [fsr_pkg::POS_W-1:0]      width,
  input  logic signed [fsr_pkg::POS_W-1:0]      height,
  input  logic        [fsr_pkg::RADIUS_W-1:0]   radius,
  input  logic        [fsr_pkg::COLOR_W-1:0]    color,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic        [fsr_pkg::COLOR_W-1:0]    read_color,
  output logic        [fsr_pkg::COLOR_W-1:0]    red_level,
  output logic        [fsr_pkg::COLOR_W-1:0]    green_level,
  output logic        [fsr_pkg::COLOR_W-1:0]    blue_level
);

  localparam int CW = fsr_pkg::COORD_W;

  // command registers
  logic        [fsr_pkg::MODE_W-1:0]   mode_r;
  logic signed [fsr_pkg::POS_W-1:0]    x_r, y_r, w_r, h_r;
  logic        [fsr_pkg::RADIUS_W-1:0] rad_r;
  logic        [fsr_pkg::COLOR_W-1:0]  color_r;

  // walk setup
  logic        [fsr_pkg::COL_W-1:0]    xs_r, xe_r, i_r;
  logic        [fsr_pkg::ROW_W-1:0]    ys_r, ye_r, j_r;
  logic                                scan_vld_r;
  fsr_pkg::scan_kind_t                 kind_r;
  logic        [fsr_pkg::COLOR_W-1:0]  wcolor_r;
  logic signed [CW-1:0]                cx_r, cy_r;
  logic        [fsr_pkg::RR_W-1:0]     rr_r;

  // pixel pipeline
  logic                                p1_vld_r, p2_vld_r;
  logic signed [CW-1:0]                p1_dx_r, p1_dy_r;
  logic        [fsr_pkg::ADDR_W-1:0]   p1_addr_r, p2_addr_r;
  logic                                p1_border_r, p2_border_r;
  logic        [fsr_pkg::SQ_W-1:0]     p2_sqx_r, p2_sqy_r;

  // pixel store
  logic [fsr_pkg::COLOR_W-1:0] mem [fsr_pkg::NUM_PIX];
  logic [fsr_pkg::COLOR_W-1:0] rd_data_r;
  logic [fsr_pkg::ADDR_W-1:0]  rd_addr;
  logic                        rd_in_range;

  // setup arithmetic
  logic signed [CW-1:0] x_e, y_e, w_e, h_e, r_e;
  logic signed [CW-1:0] xs_w, ys_w, hi_x, hi_y, lim_x, lim_y, xe_w, ye_w;
  logic                 is_circ, empty, draw;
  fsr_pkg::scan_kind_t  kind_nxt;
  logic [fsr_pkg::COL_W-1:0] xs_n, xe_n;
  logic [fsr_pkg::ROW_W-1:0] ys_n, ye_n;

  logic signed [CW-1:0]          i_s, j_s;
  logic signed [2*CW-1:0]        prod_x, prod_y;
  logic [fsr_pkg::SQ_W:0]        dsum;
  logic                          wr_en;
  logic                          last_row, last_col;

  always_comb begin
    x_e     = CW'(x_r);
    y_e     = CW'(y_r);
    w_e     = CW'(w_r);
    h_e     = CW'(h_r);
    r_e     = $signed({{(CW-fsr_pkg::RADIUS_W){1'b0}}, rad_r});
    is_circ = (mode_r == fsr_pkg::MODE_CIRCLE);
    xs_w    = (x_e < 0) ? '0 : x_e;
    ys_w    = (y_e < 0) ? '0 : y_e;
    // circle end is exclusive: min(a, W) - 1 == min(a - 1, W - 1)
    hi_x    = is_circ ? (x_e + r_e + r_e - CW'(1)) : (x_e + w_e);
    hi_y    = is_circ ? (y_e + r_e + r_e - CW'(1)) : (y_e + h_e);
    lim_x   = is_circ ? CW'(fsr_pkg::DISP_WIDTH - 1) : CW'(fsr_pkg::DISP_WIDTH);
    lim_y   = is_circ ? CW'(fsr_pkg::DISP_HEIGHT - 1) : CW'(fsr_pkg::DISP_HEIGHT);
    xe_w    = (hi_x < lim_x) ? hi_x : lim_x;
    ye_w    = (hi_y < lim_y) ? hi_y : lim_y;
    empty   = (xs_w > xe_w) || (ys_w > ye_w);
    xs_n    = xs_w[fsr_pkg::COL_W-1:0];
    xe_n    = xe_w[fsr_pkg::COL_W-1:0];
    ys_n    = ys_w[fsr_pkg::ROW_W-1:0];
    ye_n    = ye_w[fsr_pkg::ROW_W-1:0];
    draw    = 1'b0;
    kind_nxt = fsr_pkg::SCAN_SOLID;
    unique case (mode_r) inside
      fsr_pkg::MODE_FILL: begin
        draw  = 1'b1;
        empty = 1'b0;
        xs_n  = '0;
        ys_n  = '0;
        xe_n  = fsr_pkg::COL_W'(fsr_pkg::DISP_WIDTH);
        ye_n  = fsr_pkg::ROW_W'(fsr_pkg::DISP_HEIGHT);
      end
      fsr_pkg::MODE_RECT: begin
        draw = 1'b1;
      end
      fsr_pkg::MODE_OUTLINE: begin
        draw     = 1'b1;
        kind_nxt = fsr_pkg::SCAN_BORDER;
      end
      fsr_pkg::MODE_CIRCLE: begin
        draw     = 1'b1;
        kind_nxt = fsr_pkg::SCAN_DISC;
      end
      default: draw = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.cmd_load) begin
      mode_r  <= mode;
      x_r     <= x_pos;
      y_r     <= y_pos;
      w_r     <= width;
      h_r     <= height;
      rad_r   <= radius;
      color_r <= color;
    end
  end

  assign last_row = (j_r == ye_r);
  assign last_col = (i_r == xe_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_vld_r <= 1'b0;
    end else if (ctl.clear_setup) begin
      scan_vld_r <= 1'b1;
    end else if (ctl.setup) begin
      scan_vld_r <= draw && !empty;
    end else if (ctl.step && scan_vld_r && last_row && last_col) begin
      scan_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear_setup) begin
      xs_r     <= '0;
      ys_r     <= '0;
      xe_r     <= fsr_pkg::COL_W'(fsr_pkg::DISP_WIDTH);
      ye_r     <= fsr_pkg::ROW_W'(fsr_pkg::DISP_HEIGHT);
      i_r      <= '0;
      j_r      <= '0;
      kind_r   <= fsr_pkg::SCAN_SOLID;
      wcolor_r <= '0;
    end else if (ctl.setup) begin
      xs_r     <= xs_n;
      ys_r     <= ys_n;
      xe_r     <= xe_n;
      ye_r     <= ye_n;
      i_r      <= xs_n;
      j_r      <= ys_n;
      kind_r   <= kind_nxt;
      wcolor_r <= color_r;
      cx_r     <= x_e + r_e;
      cy_r     <= y_e + r_e;
      rr_r     <= rad_r * rad_r;
    end else if (ctl.step && scan_vld_r) begin
      // advance down the column, then step to the next one
      if (last_row) begin
        j_r <= ys_r;
        if (!last_col) i_r <= i_r + fsr_pkg::COL_W'(1);
      end else begin
        j_r <= j_r + fsr_pkg::ROW_W'(1);
      end
    end
  end

  // stage 1: offsets, address, edge flag
  assign i_s = $signed(CW'(i_r));
  assign j_s = $signed(CW'(j_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= scan_vld_r && ctl.step;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_dx_r     <= i_s - cx_r;
    p1_dy_r     <= j_s - cy_r;
    p1_addr_r   <= fsr_pkg::pix_addr(i_r, j_r);
    p1_border_r <= (i_r == xs_r) || last_col || (j_r == ys_r) || last_row;
  end

  // stage 2: squares
  assign prod_x = p1_dx_r * p1_dx_r;
  assign prod_y = p1_dy_r * p1_dy_r;

  always_ff @(posedge clk) begin
    p2_sqx_r    <= prod_x[fsr_pkg::SQ_W-1:0];
    p2_sqy_r    <= prod_y[fsr_pkg::SQ_W-1:0];
    p2_addr_r   <= p1_addr_r;
    p2_border_r <= p1_border_r;
  end

  // stage 3: decide and write
  assign dsum = {1'b0, p2_sqx_r} + {1'b0, p2_sqy_r};

  always_comb begin
    wr_en = 1'b0;
    unique case (kind_r)
      fsr_pkg::SCAN_SOLID:  wr_en = p2_vld_r;
      fsr_pkg::SCAN_BORDER: wr_en = p2_vld_r && p2_border_r;
      fsr_pkg::SCAN_DISC:   wr_en = p2_vld_r && (dsum <= (fsr_pkg::SQ_W + 1)'(rr_r));
      default:              wr_en = 1'b0;
    endcase
  end

  assign rd_in_range = (x_r >= 0) && (x_r <= fsr_pkg::POS_W'(fsr_pkg::DISP_WIDTH))
                    && (y_r >= 0) && (y_r <= fsr_pkg::POS_W'(fsr_pkg::DISP_HEIGHT));
  assign rd_addr = rd_in_range ?
      fsr_pkg::pix_addr(x_r[fsr_pkg::COL_W-1:0], y_r[fsr_pkg::ROW_W-1:0]) : '0;

  always_ff @(posedge clk) begin
    if (wr_en) mem[p2_addr_r] <= wcolor_r;
    rd_data_r <= mem[rd_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      if ((mode_r == fsr_pkg::MODE_READ) && rd_in_range) begin
        read_color  <= rd_data_r;
        red_level   <= {rd_data_r[7:5], 5'b0};
        green_level <= {rd_data_r[4:2], 5'b0};
        blue_level  <= {rd_data_r[1:0], 6'b0};
      end else begin
        read_color  <= '0;
        red_level   <= '0;
        green_level <= '0;
        blue_level  <= '0;
      end
    end
  end

  assign sts.draw      = draw;
  assign sts.scan_end  = !scan_vld_r || (last_row && last_col);
  assign sts.pipe_busy = p1_vld_r || p2_vld_r;
  assign sts.out_free  = !out_valid || out_ready;

  `ASSERT_IMPL(a_wr_addr_range, p2_vld_r, 32'(p2_addr_r) < 32'(fsr_pkg::NUM_PIX))
  `ASSERT_IMPL(a_scan_in_box, scan_vld_r, i_r >= xs_r && i_r <= xe_r && j_r >= ys_r && j_r <= ye_r)
  `ASSERT_IMPL(a_quiet_at_result, ctl.out_load, !p1_vld_r && !p2_vld_r && !wr_en)

endmodule

// File: verif/tb_framebuffer_shape_rasterizer.sv
`timescale 1ns / 1ps

module tb_framebuffer_shape_rasterizer;

  localparam int RAND_CMDS    = 75;
  localparam int SHOW_LIMIT   = 10;
  localparam int IDLE_LIMIT   = 4 * (fsr_pkg::NUM_PIX + 64);
  localparam int DRAIN_CYCLES = 16;
  localparam int MODE_SPAN    = 1 << fsr_pkg::MODE_W;

  typedef struct {
    logic [fsr_pkg::MODE_W-1:0]   mode;
    logic [fsr_pkg::POS_W-1:0]    x_pos;
    logic [fsr_pkg::POS_W-1:0]    y_pos;
    logic [fsr_pkg::POS_W-1:0]    width;
    logic [fsr_pkg::POS_W-1:0]    height;
    logic [fsr_pkg::RADIUS_W-1:0] radius;
    logic [fsr_pkg::COLOR_W-1:0]  color;
  } fsr_cmd_t;

  typedef struct packed {
    logic [fsr_pkg::COLOR_W-1:0] read_color;
    logic [fsr_pkg::COLOR_W-1:0] red_level;
    logic [fsr_pkg::COLOR_W-1:0] green_level;
    logic [fsr_pkg::COLOR_W-1:0] blue_level;
  } fsr_pixel_t;

  class fsr_scoreboard;
    bit [fsr_pkg::COLOR_W-1:0] pixels [fsr_pkg::NUM_PIX];
    fsr_pixel_t                answers_q [$];
    int                        mismatches;
    int                        checked;

    function void paint(int col, int row, bit [fsr_pkg::COLOR_W-1:0] c);
      if (col >= 0 && col < fsr_pkg::COLS && row >= 0 && row < fsr_pkg::ROWS) begin
        pixels[col * fsr_pkg::ROWS + row] = c;
      end
    endfunction

    // Apply one accepted command to the pixel model and queue its answer.
    function void take_command(fsr_cmd_t cmd);
      int         x, y, w, h, r, xs, xe, ys, ye, i, j;
      longint     cx, cy, rr, dx, dy;
      fsr_pixel_t res;
      x   = int'($signed(cmd.x_pos));
      y   = int'($signed(cmd.y_pos));
      w   = int'($signed(cmd.width));
      h   = int'($signed(cmd.height));
      r   = int'(cmd.radius);
      res = '0;
      case (cmd.mode)
        fsr_pkg::MODE_FILL: begin
          foreach (pixels[k]) pixels[k] = cmd.color;
        end
        fsr_pkg::MODE_RECT, fsr_pkg::MODE_OUTLINE: begin
          xs = (x > 0) ? x : 0;
          xe = (x + w < fsr_pkg::DISP_WIDTH) ? x + w : fsr_pkg::DISP_WIDTH;
          ys = (y > 0) ? y : 0;
          ye = (y + h < fsr_pkg::DISP_HEIGHT) ? y + h : fsr_pkg::DISP_HEIGHT;
          if (xs <= xe && ys <= ye) begin
            if (cmd.mode == fsr_pkg::MODE_RECT) begin
              for (i = xs; i <= xe; i++)
                for (j = ys; j <= ye; j++) paint(i, j, cmd.color);
            end else begin
              for (i = xs; i <= xe; i++) begin
                paint(i, ys, cmd.color);
                paint(i, ye, cmd.color);
              end
              for (j = ys; j < ye; j++) begin
                paint(xs, j, cmd.color);
                paint(xe, j, cmd.color);
              end
            end
          end
        end
        fsr_pkg::MODE_CIRCLE: begin
          cx = longint'(x) + r;
          cy = longint'(y) + r;
          rr = longint'(r) * r;
          xs = (x > 0) ? x : 0;
          xe = (x + 2 * r < fsr_pkg::DISP_WIDTH) ? x + 2 * r : fsr_pkg::DISP_WIDTH;
          ys = (y > 0) ? y : 0;
          ye = (y + 2 * r < fsr_pkg::DISP_HEIGHT) ? y + 2 * r : fsr_pkg::DISP_HEIGHT;
          // end column and row are exclusive here
          for (i = xs; i < xe; i++) begin
            for (j = ys; j < ye; j++) begin
              dx = longint'(i) - cx;
              dy = longint'(j) - cy;
              if (dx * dx + dy * dy <= rr) paint(i, j, cmd.color);
            end
          end
        end
        fsr_pkg::MODE_READ: begin
          if (x >= 0 && x <= fsr_pkg::DISP_WIDTH && y >= 0 && y <= fsr_pkg::DISP_HEIGHT) begin
            res.read_color  = pixels[x * fsr_pkg::ROWS + y];
            res.red_level   = {res.read_color[7:5], 5'b0};
            res.green_level = {res.read_color[4:2], 5'b0};
            res.blue_level  = {res.read_color[1:0], 6'b0};
          end
        end
        default: ;
      endcase
      answers_q.push_back(res);
    endfunction

    function void check_result(fsr_pixel_t got);
      fsr_pixel_t want;
      if (answers_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
          $display("[%0t] result beat with no command pending: %h", $realtime, got);
        end
        return;
      end
      want = answers_q.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
          $display("[%0t] result %0d mismatch: expected color %h r %h g %h b %h,",
                   $realtime, checked, want.read_color, want.red_level,
                   want.green_level, want.blue_level);
          $display("    got color %h r %h g %h b %h", got.read_color, got.red_level,
                   got.green_level, got.blue_level);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fsr_in_if  in_bus ();
  fsr_out_if out_bus ();

  framebuffer_shape_rasterizer u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  fsr_scoreboard sb;

  bit in_gaps_on;
  bit out_stalls_on;
  int stall_left;
  int idle_cycles;
  int anchor_x;
  int anchor_y;
  int n_draws;
  int n_reads;
  int n_spare;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap(bit enabled);
    int k;
    if (!enabled) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic fsr_cmd_t make_cmd(logic [fsr_pkg::MODE_W-1:0] mode, int x, int y,
                                        int w, int h, int r, int c);
    fsr_cmd_t cmd;
    cmd.mode   = mode;
    cmd.x_pos  = fsr_pkg::POS_W'(x);
    cmd.y_pos  = fsr_pkg::POS_W'(y);
    cmd.width  = fsr_pkg::POS_W'(w);
    cmd.height = fsr_pkg::POS_W'(h);
    cmd.radius = fsr_pkg::RADIUS_W'(r);
    cmd.color  = fsr_pkg::COLOR_W'(c);
    return cmd;
  endfunction

  function automatic fsr_cmd_t rand_cmd();
    fsr_cmd_t cmd;
    int       k;
    k = $urandom_range(0, 99);
    if (k < 3)       cmd.mode = fsr_pkg::MODE_FILL;
    else if (k < 23) cmd.mode = fsr_pkg::MODE_RECT;
    else if (k < 38) cmd.mode = fsr_pkg::MODE_OUTLINE;
    else if (k < 53) cmd.mode = fsr_pkg::MODE_CIRCLE;
    else if (k < 93) cmd.mode = fsr_pkg::MODE_READ;
    else cmd.mode = fsr_pkg::MODE_W'($urandom_range(int'(fsr_pkg::MODE_READ) + 1,
                                                    MODE_SPAN - 1));
    // keep most shapes small and near the store
    cmd.x_pos  = fsr_pkg::POS_W'(int'($urandom_range(0, fsr_pkg::DISP_WIDTH + 16)) - 8);
    cmd.y_pos  = fsr_pkg::POS_W'(int'($urandom_range(0, fsr_pkg::DISP_HEIGHT + 16)) - 8);
    cmd.width  = fsr_pkg::POS_W'(int'($urandom_range(0, 44)) - 4);
    cmd.height = fsr_pkg::POS_W'(int'($urandom_range(0, 44)) - 4);
    cmd.radius = fsr_pkg::RADIUS_W'($urandom_range(0, 24));
    cmd.color  = fsr_pkg::COLOR_W'($urandom);
    if (cmd.mode == fsr_pkg::MODE_READ && $urandom_range(0, 1) == 1) begin
      cmd.x_pos = fsr_pkg::POS_W'(anchor_x + int'($urandom_range(0, 20)));
      cmd.y_pos = fsr_pkg::POS_W'(anchor_y + int'($urandom_range(0, 20)));
    end
    if ($urandom_range(0, 9) == 0) cmd.x_pos  = fsr_pkg::POS_W'($urandom);
    if ($urandom_range(0, 9) == 0) cmd.y_pos  = fsr_pkg::POS_W'($urandom);
    if ($urandom_range(0, 9) == 0) cmd.width  = fsr_pkg::POS_W'($urandom);
    if ($urandom_range(0, 9) == 0) cmd.height = fsr_pkg::POS_W'($urandom);
    if ($urandom_range(0, 9) == 0) cmd.radius = fsr_pkg::RADIUS_W'($urandom);
    if (cmd.mode inside {fsr_pkg::MODE_RECT, fsr_pkg::MODE_OUTLINE, fsr_pkg::MODE_CIRCLE}) begin
      anchor_x = int'($signed(cmd.x_pos));
      anchor_y = int'($signed(cmd.y_pos));
    end
    return cmd;
  endfunction

  task automatic send_cmd(input fsr_cmd_t cmd);
    int gap;
    gap = pick_gap(in_gaps_on);
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid  <= 1'b1;
    in_bus.mode   <= cmd.mode;
    in_bus.x_pos  <= cmd.x_pos;
    in_bus.y_pos  <= cmd.y_pos;
    in_bus.width  <= cmd.width;
    in_bus.height <= cmd.height;
    in_bus.radius <= cmd.radius;
    in_bus.color  <= cmd.color;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
  endtask

  // Receiver side: drop ready for random stretches.
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else begin
        out_bus.ready <= 1'b1;
        stall_left    <= pick_gap(out_stalls_on);
      end
    end
  end

  always @(posedge clk) begin : monitor
    fsr_cmd_t   seen;
    fsr_pixel_t got;
    bit         moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1) begin
        seen.mode   = in_bus.mode;
        seen.x_pos  = in_bus.x_pos;
        seen.y_pos  = in_bus.y_pos;
        seen.width  = in_bus.width;
        seen.height = in_bus.height;
        seen.radius = in_bus.radius;
        seen.color  = in_bus.color;
        sb.take_command(seen);
        if (seen.mode == fsr_pkg::MODE_READ) n_reads++;
        else if (seen.mode > fsr_pkg::MODE_READ) n_spare++;
        else n_draws++;
        moved = 1'b1;
      end
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        got.read_color  = out_bus.read_color;
        got.red_level   = out_bus.red_level;
        got.green_level = out_bus.green_level;
        got.blue_level  = out_bus.blue_level;
        sb.check_result(got);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                 idle_cycles, sb.answers_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int m;
    int real_cmds;
    fsr_cmd_t cmd;
    sb            = new;
    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.mode   = '0;
    in_bus.x_pos  = '0;
    in_bus.y_pos  = '0;
    in_bus.width  = '0;
    in_bus.height = '0;
    in_bus.radius = '0;
    in_bus.color  = '0;
    out_bus.ready = 1'b0;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Store is cleared after reset.
    send_cmd(make_cmd(fsr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(fsr_pkg::MODE_FILL, 0, 0, 0, 0, 0, 8'hFF));
    send_cmd(make_cmd(fsr_pkg::MODE_READ, fsr_pkg::DISP_WIDTH, fsr_pkg::DISP_HEIGHT,
                      0, 0, 0, 0));
    // Empty clips: box left of the store, box right of the store.
    send_cmd(make_cmd(fsr_pkg::MODE_RECT, -32768, -32768, -32768, -32768, 0, 8'h00));
    send_cmd(make_cmd(fsr_pkg::MODE_RECT, 32767, 32767, 32767, 32767, 32767, 8'h00));
    // Clip at both corners of the store.
    send_cmd(make_cmd(fsr_pkg::MODE_RECT, -3, -2, 12, 9, 0, 8'h00));
    send_cmd(make_cmd(fsr_pkg::MODE_RECT, fsr_pkg::DISP_WIDTH - 2, fsr_pkg::DISP_HEIGHT - 3,
                      10, 10, 0, 8'hB9));
    send_cmd(make_cmd(fsr_pkg::MODE_READ, fsr_pkg::DISP_WIDTH, fsr_pkg::DISP_HEIGHT,
                      0, 0, 0, 0));
    // Outline on clipped edges, then a one-pixel outline.
    send_cmd(make_cmd(fsr_pkg::MODE_OUTLINE, -5, -5, 25, 30, 0, 8'h1C));
    send_cmd(make_cmd(fsr_pkg::MODE_OUTLINE, 40, 50, 0, 0, 0, 8'hE3));
    send_cmd(make_cmd(fsr_pkg::MODE_READ, 0, 10, 0, 0, 0, 0));
    send_cmd(make_cmd(fsr_pkg::MODE_READ, 40, 50, 0, 0, 0, 0));
    // Zero radius draws nothing; the huge circle covers all but the last column and row.
    send_cmd(make_cmd(fsr_pkg::MODE_CIRCLE, 60, 60, 0, 0, 0, 8'h00));
    send_cmd(make_cmd(fsr_pkg::MODE_CIRCLE, -32768, -32768, 0, 0, 32767, 8'h92));
    send_cmd(make_cmd(fsr_pkg::MODE_READ, fsr_pkg::DISP_WIDTH, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(fsr_pkg::MODE_CIRCLE, fsr_pkg::DISP_WIDTH - 28,
                      fsr_pkg::DISP_HEIGHT - 30, 0, 0, 20, 8'h6D));
    send_cmd(make_cmd(fsr_pkg::MODE_CIRCLE, 30, 40, 0, 0, 10, 8'h4A));
    send_cmd(make_cmd(fsr_pkg::MODE_READ, 40, 50, 0, 0, 0, 0));
    send_cmd(make_cmd(fsr_pkg::MODE_READ, 30, 40, 0, 0, 0, 0));
    // Reads outside the store answer zero.
    send_cmd(make_cmd(fsr_pkg::MODE_READ, -1, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(fsr_pkg::MODE_READ, 0, fsr_pkg::DISP_HEIGHT + 1, 0, 0, 0, 0));
    send_cmd(make_cmd(fsr_pkg::MODE_READ, fsr_pkg::DISP_WIDTH + 1, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(fsr_pkg::MODE_READ, 32767, -32768, 0, 0, 0, 0));
    for (m = int'(fsr_pkg::MODE_READ) + 1; m < MODE_SPAN; m++) begin
      send_cmd(make_cmd(fsr_pkg::MODE_W'(m), -32768, 32767, -32768, 32767, 32767, 8'hFF));
    end

    real_cmds = 0;
    while (real_cmds < RAND_CMDS) begin
      // rotate idling: both sides, receiver only, sender only
      if (real_cmds % 25 == 0) begin
        in_gaps_on    = ((real_cmds / 25) % 3 != 1);
        out_stalls_on = ((real_cmds / 25) % 3 != 2);
      end
      cmd = rand_cmd();
      send_cmd(cmd);
      if (cmd.mode <= fsr_pkg::MODE_READ) real_cmds++;
    end
    @(negedge clk);
    in_bus.valid <= 1'b0;

    while (sb.answers_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d draw commands, %0d pixel reads and %0d commands in unused modes.",
             n_draws, n_reads, n_spare);
    $display("Compared %0d result beats, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.answers_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/fsr_pkg.sv
hw/rtl/fsr_if.sv
hw/rtl/fsr_ctrl.sv
hw/rtl/fsr_datapath.sv
hw/rtl/framebuffer_shape_rasterizer.sv
verif/tb_framebuffer_shape_rasterizer.sv
